// ----- hw/rtl/plist_pkg.sv -----
// Shared types and constants for the positional list engine.
`default_nettype none
package plist_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 7;
  localparam int LEN_W  = 5;

  typedef enum logic [2:0] {
    MODE_DISPLAY    = 3'd0,
    MODE_INS_HEAD   = 3'd1,
    MODE_INS_TAIL   = 3'd2,
    MODE_INS_POS    = 3'd3,
    MODE_DEL_HEAD   = 3'd4,
    MODE_DEL_TAIL   = 3'd5,
    MODE_DEL_POS    = 3'd6,
    MODE_UNUSED     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DISP = 1'b1
  } state_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          idx;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/plist_cell.sv -----
// One storage cell of the list chain, holding a single element.
`default_nettype none
module plist_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                                   clk,
  input  wire plist_pkg::cell_ctl_t                   ctl,
  input  wire logic signed [plist_pkg::DATA_W-1:0]    left_val,
  input  wire logic signed [plist_pkg::DATA_W-1:0]    right_val,
  input  wire logic signed [plist_pkg::DATA_W-1:0]    head_val,
  output logic signed [plist_pkg::DATA_W-1:0]         val,
  output logic signed [plist_pkg::DATA_W-1:0]         sel_val
);

  localparam logic [plist_pkg::IDX_W-1:0] MY_IDX = plist_pkg::IDX_W'(INDEX);

  logic signed [plist_pkg::DATA_W-1:0] val_r;
  logic signed [plist_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      plist_pkg::CELL_INSERT: begin
        if (MY_IDX == ctl.idx) begin
          val_nxt = ctl.value;
        end else if (MY_IDX > ctl.idx) begin
          val_nxt = left_val;
        end
      end
      plist_pkg::CELL_DELETE: begin
        if (MY_IDX >= ctl.idx) begin
          val_nxt = right_val;
        end
      end
      plist_pkg::CELL_ROTATE: begin
        if (MY_IDX == ctl.idx) begin
          val_nxt = head_val;
        end else if (MY_IDX < ctl.idx) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val     = val_r;
  assign sel_val = (MY_IDX == ctl.idx) ? val_r : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/positional_list_engine.sv -----
// Top level of the positional list engine: control sequencer and cell chain.
// Inserts and deletes give their status in the cycle after they are accepted.
// Display of a non-empty list enters the display state, then gives one element per cycle
// while the output is free, rotating the chain one place per result, holding the input off.
// A stalled result holds the input off until it has been taken.
// Reset empties the list; element contents are left as they were.
`default_nettype none
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          in_mode,
  input  wire logic signed [plist_pkg::DATA_W-1:0] in_value,
  input  wire logic [5:0]                          in_position,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_status,
  output logic signed [plist_pkg::DATA_W-1:0]      out_element,
  output logic [plist_pkg::LEN_W-1:0]              out_length,
  output logic                                     out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  plist_pkg::state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic [CNT_W-1:0]                    rem_r, rem_nxt;
  logic                                out_valid_r, out_valid_nxt;
  plist_pkg::status_t                  out_status_r, out_status_nxt;
  logic signed [plist_pkg::DATA_W-1:0] out_element_r, out_element_nxt;
  logic [plist_pkg::LEN_W-1:0]         out_length_r, out_length_nxt;
  logic                                out_last_r, out_last_nxt;

  plist_pkg::cell_ctl_t                ctl;
  logic signed [plist_pkg::DATA_W-1:0] cell_val [CAPACITY];
  logic signed [plist_pkg::DATA_W-1:0] cell_sel [CAPACITY];
  logic signed [plist_pkg::DATA_W-1:0] picked;

  logic       out_free;
  logic       accept;
  logic       load;
  logic [7:0] cnt8;
  logic [7:0] pos8;
  logic [7:0] cnt_nxt8;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plist_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_val ((i == 0) ? cell_val[i] : cell_val[(i == 0) ? 0 : i - 1]),
      .right_val((i == CAPACITY - 1) ? cell_val[i]
                                     : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .head_val (cell_val[0]),
      .val      (cell_val[i]),
      .sel_val  (cell_sel[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      picked = picked | cell_sel[i];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == plist_pkg::ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign cnt8     = 8'(count_r);
  assign pos8     = 8'(in_position);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rem_nxt         = rem_r;
    load            = 1'b0;
    out_status_nxt  = plist_pkg::STAT_OK;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    ctl.op          = plist_pkg::CELL_HOLD;
    ctl.idx         = '0;
    ctl.value       = in_value;

    case (state_r)
      plist_pkg::ST_IDLE: begin
        if (accept) begin
          case (plist_pkg::mode_t'(in_mode))
            plist_pkg::MODE_DISPLAY: begin
              if (count_r == '0) begin
                load           = 1'b1;
                out_status_nxt = plist_pkg::STAT_EMPTY;
              end else begin
                state_nxt = plist_pkg::ST_DISP;
                rem_nxt   = count_r;
              end
            end
            plist_pkg::MODE_INS_HEAD, plist_pkg::MODE_INS_TAIL,
            plist_pkg::MODE_INS_POS: begin
              load = 1'b1;
              if (cnt8 == 8'(CAPACITY)) begin
                out_status_nxt = plist_pkg::STAT_FULL;
              end else if ((plist_pkg::mode_t'(in_mode) == plist_pkg::MODE_INS_POS) &&
                           ((pos8 == 8'd0) || (pos8 > cnt8 + 8'd1))) begin
                out_status_nxt = plist_pkg::STAT_RANGE;
              end else begin
                ctl.op    = plist_pkg::CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
                case (plist_pkg::mode_t'(in_mode))
                  plist_pkg::MODE_INS_HEAD: ctl.idx = '0;
                  plist_pkg::MODE_INS_TAIL: ctl.idx = plist_pkg::IDX_W'(cnt8);
                  default:                  ctl.idx = plist_pkg::IDX_W'(pos8 - 8'd1);
                endcase
              end
            end
            plist_pkg::MODE_DEL_HEAD, plist_pkg::MODE_DEL_TAIL,
            plist_pkg::MODE_DEL_POS: begin
              load = 1'b1;
              case (plist_pkg::mode_t'(in_mode))
                plist_pkg::MODE_DEL_HEAD: ctl.idx = '0;
                plist_pkg::MODE_DEL_TAIL: ctl.idx = plist_pkg::IDX_W'(cnt8 - 8'd1);
                default:                  ctl.idx = plist_pkg::IDX_W'(pos8 - 8'd1);
              endcase
              if (count_r == '0) begin
                out_status_nxt = plist_pkg::STAT_EMPTY;
              end else if ((plist_pkg::mode_t'(in_mode) == plist_pkg::MODE_DEL_POS) &&
                           ((pos8 == 8'd0) || (pos8 > cnt8))) begin
                out_status_nxt = plist_pkg::STAT_RANGE;
              end else begin
                ctl.op          = plist_pkg::CELL_DELETE;
                count_nxt       = count_r - CNT_W'(1);
                out_element_nxt = picked;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      plist_pkg::ST_DISP: begin
        if (out_free) begin
          load            = 1'b1;
          out_element_nxt = cell_val[0];
          out_last_nxt    = (rem_r == CNT_W'(1));
          ctl.op          = plist_pkg::CELL_ROTATE;
          ctl.idx         = plist_pkg::IDX_W'(cnt8 - 8'd1);
          rem_nxt         = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = plist_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = plist_pkg::ST_IDLE;
    endcase

    cnt_nxt8       = 8'(count_nxt);
    out_length_nxt = cnt_nxt8[plist_pkg::LEN_W-1:0];

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plist_pkg::ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r  <= out_status_nxt;
      out_element_r <= out_element_nxt;
      out_length_r  <= out_length_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_length  = out_length_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

// ----- sim/positional_list_engine_tb.sv -----
// Self-checking testbench for the positional list engine against a shadow list.
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP     = 16;
  localparam int RANDOM_OPS   = 345;
  localparam int PHASE_OPS    = 40;
  localparam int CALM_OPS     = 60;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 800000;

  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  typedef struct {
    bit                  pause;
    plist_pkg::mode_t    mode;
    logic signed [31:0]  value;
    logic [5:0]          pos;
  } list_op_t;

  typedef struct {
    plist_pkg::status_t  status;
    logic signed [31:0]  element;
    logic [4:0]          length;
    logic                last;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_mode = plist_pkg::MODE_DISPLAY;
  logic signed [31:0] in_value = '0;
  logic [5:0]         in_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_element;
  logic [4:0]         out_length;
  logic               out_last;

  list_op_t           pending_ops[$];
  list_result_t       expected_results[$];
  logic signed [31:0] shadow_list[LIST_CAP];
  int unsigned        shadow_len = 0;
  int unsigned        planned_len = 0;
  int                 errors = 0;
  int                 cycles = 0;
  int                 send_gap = 0;
  int                 recv_gap = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  int                 ops_taken = 0;
  bit                 calm = 1'b0;
  bit                 rx_holding = 1'b0;

  positional_list_engine #(.CAPACITY(LIST_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_element(out_element),
    .out_length (out_length),
    .out_last   (out_last)
  );

  always #4 clk = ~clk;

  function automatic void push_result(plist_pkg::status_t s, logic signed [31:0] e, logic l);
    expected_results.push_back('{s, e, shadow_len[4:0], l});
  endfunction

  function automatic void apply_list_op(plist_pkg::mode_t m, logic signed [31:0] v,
                                        logic [5:0] p);
    int unsigned        slot;
    logic signed [31:0] removed;
    case (m)
      plist_pkg::MODE_DISPLAY: begin
        if (shadow_len == 0) begin
          push_result(plist_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            push_result(plist_pkg::STAT_OK, shadow_list[i], i + 1 == shadow_len);
        end
      end
      plist_pkg::MODE_INS_HEAD, plist_pkg::MODE_INS_TAIL, plist_pkg::MODE_INS_POS: begin
        if (shadow_len >= LIST_CAP) begin
          push_result(plist_pkg::STAT_FULL, '0, 1'b1);
          return;
        end
        if (m == plist_pkg::MODE_INS_HEAD) begin
          slot = 0;
        end else if (m == plist_pkg::MODE_INS_TAIL) begin
          slot = shadow_len;
        end else begin
          if (p < 1 || p > shadow_len + 1) begin
            push_result(plist_pkg::STAT_RANGE, '0, 1'b1);
            return;
          end
          slot = p - 1;
        end
        for (int i = shadow_len; i > slot; i--)
          shadow_list[i] = shadow_list[i-1];
        shadow_list[slot] = v;
        shadow_len++;
        push_result(plist_pkg::STAT_OK, '0, 1'b1);
      end
      plist_pkg::MODE_DEL_HEAD, plist_pkg::MODE_DEL_TAIL, plist_pkg::MODE_DEL_POS: begin
        if (shadow_len == 0) begin
          push_result(plist_pkg::STAT_EMPTY, '0, 1'b1);
          return;
        end
        if (m == plist_pkg::MODE_DEL_HEAD) begin
          slot = 0;
        end else if (m == plist_pkg::MODE_DEL_TAIL) begin
          slot = shadow_len - 1;
        end else begin
          if (p < 1 || p > shadow_len) begin
            push_result(plist_pkg::STAT_RANGE, '0, 1'b1);
            return;
          end
          slot = p - 1;
        end
        removed = shadow_list[slot];
        for (int i = slot; i + 1 < shadow_len; i++)
          shadow_list[i] = shadow_list[i+1];
        shadow_len--;
        push_result(plist_pkg::STAT_OK, removed, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic queue_op(plist_pkg::mode_t m, logic signed [31:0] v, logic [5:0] p);
    pending_ops.push_back('{1'b0, m, v, p});
    case (m)
      plist_pkg::MODE_INS_HEAD, plist_pkg::MODE_INS_TAIL:
        if (planned_len < LIST_CAP) planned_len++;
      plist_pkg::MODE_INS_POS:
        if (planned_len < LIST_CAP && p >= 1 && p <= planned_len + 1) planned_len++;
      plist_pkg::MODE_DEL_HEAD, plist_pkg::MODE_DEL_TAIL:
        if (planned_len > 0) planned_len--;
      plist_pkg::MODE_DEL_POS:
        if (planned_len > 0 && p >= 1 && p <= planned_len) planned_len--;
      default: ;
    endcase
  endtask

  task automatic queue_pause();
    pending_ops.push_back('{1'b1, plist_pkg::MODE_DISPLAY, '0, '0});
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int               real_ops;
    int               kind;
    int               r;
    plist_pkg::mode_t m;
    logic [5:0]       p;

    queue_op(plist_pkg::MODE_DISPLAY, '0, '0);
    queue_op(plist_pkg::MODE_DEL_HEAD, '0, '0);
    queue_op(plist_pkg::MODE_DEL_TAIL, '0, '0);
    queue_op(plist_pkg::MODE_DEL_POS, '0, 6'd1);
    queue_op(plist_pkg::MODE_INS_POS, 32'sd7, 6'd0);
    queue_op(plist_pkg::MODE_INS_POS, 32'sd7, 6'd2);
    queue_op(plist_pkg::MODE_INS_POS, 32'sd5, 6'd1);
    queue_op(plist_pkg::MODE_INS_HEAD, 32'sh8000_0000, '0);
    queue_op(plist_pkg::MODE_INS_TAIL, 32'sh7fff_ffff, '0);
    queue_op(plist_pkg::MODE_INS_POS, -32'sd1, 6'd4);
    queue_op(plist_pkg::MODE_INS_POS, 32'sd9, 6'd63);
    queue_op(plist_pkg::MODE_DISPLAY, '0, '0);
    queue_op(plist_pkg::MODE_DEL_POS, '0, 6'd0);
    queue_op(plist_pkg::MODE_DEL_POS, '0, 6'd5);
    queue_op(plist_pkg::MODE_DEL_POS, '0, 6'd63);
    queue_op(plist_pkg::MODE_DEL_POS, '0, 6'd2);
    queue_op(plist_pkg::MODE_DEL_TAIL, '0, '0);
    queue_op(plist_pkg::MODE_DEL_HEAD, '0, '0);
    queue_op(plist_pkg::MODE_DEL_POS, '0, 6'd1);
    queue_op(plist_pkg::MODE_UNUSED, -32'sd1, 6'd63);
    queue_op(plist_pkg::MODE_DISPLAY, '0, '0);
    queue_op(plist_pkg::MODE_INS_TAIL, '0, '0);
    queue_op(plist_pkg::MODE_DEL_TAIL, '0, '0);
    queue_op(plist_pkg::MODE_INS_HEAD, 32'sd1, '0);
    queue_op(plist_pkg::MODE_DEL_HEAD, '0, '0);
    queue_pause();

    real_ops = 0;
    while (real_ops < RANDOM_OPS) begin
      kind = (real_ops / PHASE_OPS) % 3;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        m = plist_pkg::MODE_UNUSED;
      end else begin
        r = $urandom_range(0, 19);
        case (kind)
          PHASE_FILL:
            m = (r < 16) ? plist_pkg::mode_t'($urandom_range(1, 3)) :
                (r < 18) ? plist_pkg::MODE_DISPLAY : plist_pkg::mode_t'($urandom_range(4, 6));
          PHASE_DRAIN:
            m = (r < 16) ? plist_pkg::mode_t'($urandom_range(4, 6)) :
                (r < 18) ? plist_pkg::MODE_DISPLAY : plist_pkg::mode_t'($urandom_range(1, 3));
          default:
            m = (r < 8) ? plist_pkg::mode_t'($urandom_range(1, 3)) :
                (r < 16) ? plist_pkg::mode_t'($urandom_range(4, 6)) : plist_pkg::MODE_DISPLAY;
        endcase
        real_ops++;
      end
      if ($urandom_range(0, 99) < 85) begin
        if (m == plist_pkg::MODE_DEL_POS && planned_len > 0)
          p = 6'($urandom_range(1, planned_len));
        else
          p = 6'($urandom_range(1, planned_len + 1));
      end else begin
        p = 6'($urandom_range(0, 63));
      end
      queue_op(m, pick_value(), p);
      if (real_ops % PHASE_OPS == 0 && m != plist_pkg::MODE_UNUSED &&
          $urandom_range(0, 1) == 1)
        queue_pause();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    list_op_t nxt;
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0 && pending_ops[0].pause) begin
          in_valid <= 1'b0;
          if (!in_valid && expected_results.size() == 0)
            void'(pending_ops.pop_front());
        end else if (!calm && !rx_holding && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops.pop_front();
          in_valid    <= 1'b1;
          in_mode     <= nxt.mode;
          in_value    <= nxt.value;
          in_position <= nxt.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm <= pending_ops.size() < CALM_OPS;
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, got status %0d element %0d length %0d last %0b",
                   $realtime, out_status, out_element, out_length, out_last);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_element !== want.element ||
              out_length !== want.length || out_last !== want.last) begin
            errors++;
            $display("%0t: expected status %0d element %0d length %0d last %0b, got %0d %0d %0d %0b",
                     $realtime, want.status, want.element, want.length, want.last,
                     out_status, out_element, out_length, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_list_op(plist_pkg::mode_t'(in_mode), in_value, in_position);
        ops_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && ops_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      rx_holding <= hold_left > 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
